/* rtl/ndms_pkg.sv */
// Shared widths, register indexes and helper types for the nearest
// dinucleotide motif search core. No dependencies.
package ndms_pkg;

	localparam int BASE_W     = 8;
	localparam int POS_W      = 32;
	localparam int MM_W       = 3;
	localparam int HIT_MM_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	typedef logic [BASE_W-1:0] base_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [MM_W-1:0]   mm_t;

	// Index of each configuration register on the write port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_FIRST   = 3'd0,
		REG_LEFT_SECOND  = 3'd1,
		REG_RIGHT_FIRST  = 3'd2,
		REG_RIGHT_SECOND = 3'd3,
		REG_ALLOWED_MM   = 3'd4
	} cfg_reg_t;

endpackage

/* rtl/ndms_in_if.sv */
// Input channel of the motif search core: one base of the window per item.
// Depends on ndms_pkg.
interface ndms_in_if;
	logic               valid;
	logic               ready;
	ndms_pkg::base_t    base;
	ndms_pkg::pos_t     position;
	logic               first_of_window;
	logic               last_of_window;
	logic               motif_select;
	ndms_pkg::pos_t     reference_position;
	ndms_pkg::mm_t      prior_mismatches;

	modport source(
		output valid, base, position, first_of_window, last_of_window,
		       motif_select, reference_position, prior_mismatches,
		input  ready
	);
	modport sink(
		input  valid, base, position, first_of_window, last_of_window,
		       motif_select, reference_position, prior_mismatches,
		output ready
	);
endinterface

/* rtl/ndms_out_if.sv */
// Result channel of the motif search core: one summary per window.
// Depends on ndms_pkg.
interface ndms_out_if;
	logic               valid;
	logic               ready;
	logic               found;
	ndms_pkg::pos_t     best_position;
	ndms_pkg::pos_t     best_distance;
	ndms_pkg::mm_t      total_mismatches;

	modport source(
		output valid, found, best_position, best_distance, total_mismatches,
		input  ready
	);
	modport sink(
		input  valid, found, best_position, best_distance, total_mismatches,
		output ready
	);
endinterface

/* rtl/nearest_dinucleotide_motif_search_core.sv */
// Top level of the nearest dinucleotide motif search core.
// Depends on ndms_pkg, ndms_in_if and ndms_out_if.
//
// Usage. Software writes the two motif pairs and the allowed mismatch count
// through the write port (wr_en, wr_index, wr_data) while the core is idle.
// A window is then streamed on the bases channel, one base per item, the
// first item flagged first_of_window (it also carries the reference
// position, the motif choice and the prior mismatch count) and the last one
// flagged last_of_window. Every adjacent pair of bases is scored against the
// chosen motif, and the accepted candidate nearest to the reference is kept;
// on a tie the earlier candidate stays.
// The item that closes the window produces one item on the result channel.
//
// Throughput is one base per clock cycle: an item is captured in an input
// register and scored against the running best in the following cycle, all
// within one short compare, subtract and compare path.
// The last item of a window is captured in the input register, and the
// result is then written to the result register and presented from it.
// If the receiver stalls, the result waits in the result register while the
// next window keeps streaming; only an item that closes a window stalls
// (in the input register) until the earlier result has been taken.
// Reset clears the configuration, the scan state and both valid flags.
module nearest_dinucleotide_motif_search_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [ndms_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [ndms_pkg::CFG_DATA_W-1:0]     wr_data,
	ndms_in_if.sink                             bases,
	ndms_out_if.source                          result
);

	// Configuration registers.
	ndms_pkg::base_t left_first_q, left_second_q, right_first_q, right_second_q;
	ndms_pkg::mm_t   allowed_q;

	// Input register.
	logic            valid_s1;
	ndms_pkg::base_t base_s1;
	ndms_pkg::pos_t  position_s1;
	logic            first_s1;
	logic            last_s1;
	logic            select_s1;
	ndms_pkg::pos_t  reference_s1;
	ndms_pkg::mm_t   prior_s1;

	// Scan state.
	ndms_pkg::base_t prev_base_q;
	ndms_pkg::pos_t  prev_pos_q;
	logic            have_prev_q;
	logic            hit_q;
	ndms_pkg::pos_t  best_pos_q;
	ndms_pkg::pos_t  best_dist_q;
	logic [ndms_pkg::HIT_MM_W-1:0] best_mm_q;
	ndms_pkg::pos_t  reference_q;
	ndms_pkg::mm_t   prior_q;
	logic            select_q;

	// Result register.
	logic            out_valid_q;
	logic            found_q;
	ndms_pkg::pos_t  out_pos_q;
	ndms_pkg::pos_t  out_dist_q;
	ndms_pkg::mm_t   out_total_q;

	logic            advance;
	logic            in_take;
	ndms_pkg::base_t want_a, want_b;
	logic            miss_a, miss_b;
	logic [ndms_pkg::HIT_MM_W-1:0] pair_mm;
	logic [ndms_pkg::MM_W:0]       spend;
	logic            pair_ok;
	ndms_pkg::pos_t  cand;
	ndms_pkg::pos_t  gap;
	logic            take;

	logic            nx_found;
	ndms_pkg::pos_t  nx_pos;
	ndms_pkg::pos_t  nx_dist;
	logic [ndms_pkg::HIT_MM_W-1:0] nx_mm;
	ndms_pkg::mm_t   nx_prior;
	logic [ndms_pkg::MM_W:0]       nx_sum;
	ndms_pkg::mm_t   nx_total;

	// The input register moves on unless it holds a window's last item and
	// the result register is still occupied by an earlier result.
	assign advance = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign bases.ready = !valid_s1 || advance;
	assign in_take = bases.valid && bases.ready;

	// Pair scoring against the motif latched at the start of the window.
	assign want_a  = select_q ? right_first_q  : left_first_q;
	assign want_b  = select_q ? right_second_q : left_second_q;
	assign miss_a  = prev_base_q != want_a;
	assign miss_b  = base_s1 != want_b;
	assign pair_mm = {miss_a && miss_b, miss_a ^ miss_b};
	assign spend   = {1'b0, prior_q} + {{(ndms_pkg::MM_W - 1){1'b0}}, pair_mm};
	assign pair_ok = spend <= {1'b0, allowed_q};
	assign cand    = select_q ? position_s1 : prev_pos_q;
	assign gap     = (cand > reference_q) ? (cand - reference_q) : (reference_q - cand);

	// A first item opens a window and never closes a pair.
	assign take = !first_s1 && have_prev_q && pair_ok && (!hit_q || gap < best_dist_q);

	always_comb begin
		if (first_s1) begin
			nx_found = 1'b0;
			nx_pos   = reference_s1;
			nx_dist  = '0;
			nx_mm    = '0;
			nx_prior = prior_s1;
		end else if (take) begin
			nx_found = 1'b1;
			nx_pos   = cand;
			nx_dist  = gap;
			nx_mm    = pair_mm;
			nx_prior = prior_q;
		end else begin
			nx_found = hit_q;
			nx_pos   = hit_q ? best_pos_q : reference_q;
			nx_dist  = hit_q ? best_dist_q : '0;
			nx_mm    = best_mm_q;
			nx_prior = prior_q;
		end
		nx_sum = {1'b0, nx_prior}
			+ {{(ndms_pkg::MM_W - 1){1'b0}}, (nx_found ? nx_mm : 2'b00)};
		nx_total = nx_sum[ndms_pkg::MM_W] ? {ndms_pkg::MM_W{1'b1}}
			: nx_sum[ndms_pkg::MM_W-1:0];
	end

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_first_q   <= '0;
			left_second_q  <= '0;
			right_first_q  <= '0;
			right_second_q <= '0;
			allowed_q      <= '0;
		end else if (wr_en) begin
			unique case (ndms_pkg::cfg_reg_t'(wr_index))
				ndms_pkg::REG_LEFT_FIRST:   left_first_q   <= wr_data;
				ndms_pkg::REG_LEFT_SECOND:  left_second_q  <= wr_data;
				ndms_pkg::REG_RIGHT_FIRST:  right_first_q  <= wr_data;
				ndms_pkg::REG_RIGHT_SECOND: right_second_q <= wr_data;
				ndms_pkg::REG_ALLOWED_MM:   allowed_q      <= wr_data[ndms_pkg::MM_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: valid flag with reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bases.ready) begin
			valid_s1 <= bases.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			base_s1      <= bases.base;
			position_s1  <= bases.position;
			first_s1     <= bases.first_of_window;
			last_s1      <= bases.last_of_window;
			select_s1    <= bases.motif_select;
			reference_s1 <= bases.reference_position;
			prior_s1     <= bases.prior_mismatches;
		end
	end

	// Scan state update, one item per cycle while the input register advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_base_q <= '0;
			prev_pos_q  <= '0;
			have_prev_q <= 1'b0;
			hit_q       <= 1'b0;
			best_pos_q  <= '0;
			best_dist_q <= '0;
			best_mm_q   <= '0;
			reference_q <= '0;
			prior_q     <= '0;
			select_q    <= 1'b0;
		end else if (advance) begin
			prev_base_q <= base_s1;
			prev_pos_q  <= position_s1;
			have_prev_q <= 1'b1;
			if (first_s1) begin
				reference_q <= reference_s1;
				prior_q     <= prior_s1;
				select_q    <= select_s1;
				hit_q       <= 1'b0;
				best_pos_q  <= '0;
				best_dist_q <= '0;
				best_mm_q   <= '0;
			end else if (take) begin
				hit_q       <= 1'b1;
				best_pos_q  <= cand;
				best_dist_q <= gap;
				best_mm_q   <= pair_mm;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			found_q     <= nx_found;
			out_pos_q   <= nx_pos;
			out_dist_q  <= nx_dist;
			out_total_q <= nx_total;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.found            = found_q;
	assign result.best_position    = out_pos_q;
	assign result.best_distance    = out_dist_q;
	assign result.total_mismatches = out_total_q;

endmodule

/* rtl/ndms_checker.sv */
// Port-level checks for the motif search core and the bind that attaches
// them. Depends on ndms_pkg and nearest_dinucleotide_motif_search_core.
module ndms_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   in_last,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   out_found,
	input ndms_pkg::pos_t         out_position,
	input ndms_pkg::pos_t         out_distance,
	input ndms_pkg::mm_t          out_total
);

	// A new result rises only after a window's last item has been taken
	// and has passed from the input register into the result register.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("result appeared without a closing item two cycles before");

	// Input back-pressure only arises from a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while the result side was free");

	// Without a hit the distance is zero.
	a_no_hit_distance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_found) |-> (out_distance == '0))
		else $error("distance reported for a window without a hit");

	// A stalled result holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_found)
			&& $stable(out_position) && $stable(out_distance) && $stable(out_total)))
		else $error("stalled result changed");

endmodule

bind nearest_dinucleotide_motif_search_core ndms_checker u_ndms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (bases.valid),
	.in_ready     (bases.ready),
	.in_last      (bases.last_of_window),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_found    (result.found),
	.out_position (result.best_position),
	.out_distance (result.best_distance),
	.out_total    (result.total_mismatches)
);
